// ===== hdl/assert_macros.svh =====
// Assertion macros for the ECG heart-rate RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/ecg_hr_pkg.sv =====
// Package: types, constants and command/status structs for the ECG heart-rate unit
package ecg_hr_pkg;

  localparam int unsigned WINDOW_LEN = 256;
  localparam int unsigned WIN_W      = $clog2(WINDOW_LEN);

  localparam logic [7:0]  ID_BYTE       = 8'h08;
  localparam logic [2:0]  LAST_DATA_IDX = 3'd6;
  localparam int unsigned NUM_LEAD_BYTES = 6;
  localparam logic [15:0] RATE_RESET    = 16'd75;
  localparam logic [15:0] RATE_NUM      = 16'd60000;
  localparam int unsigned DIV_STEPS     = 16;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEAD,
    PH_DATA,
    PH_LAST,
    PH_DONE
  } parse_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_EDGE,
    ST_DIV,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic byte_take;
    logic peak_upd;
    logic edge_upd;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/ecg_hr_dp.sv =====
// Datapath: byte framer, window peak/threshold, edge detect, serial divider, output register
`include "assert_macros.svh"

module ecg_hr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic [7:0]           in_rx_byte,
  input  logic [31:0]          in_time_ms,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [15:0]          out_lead_one,
  output logic [15:0]          out_lead_two,
  output logic [15:0]          out_lead_three,
  output logic [15:0]          out_heart_rate,
  output logic                 out_beat_edge,
  input  ecg_hr_pkg::dp_cmd_t  cmd,
  output ecg_hr_pkg::dp_stat_t stat
);

  logic [15:0]               baseline_r;
  ecg_hr_pkg::parse_phase_t  phase_r, phase_nxt, eff_phase;
  logic [7:0]                head_r, head_nxt;
  logic [2:0]                count_r, count_nxt;
  logic [7:0]                pkt_r [ecg_hr_pkg::NUM_LEAD_BYTES];
  logic [31:0]               time_r;

  logic [15:0]                  peak_r;
  logic [ecg_hr_pkg::WIN_W-1:0] fill_r;
  logic [15:0]                  thr_r;
  logic                         above_r;
  logic [31:0]                  last_time_r;
  logic [15:0]                  rate_r;
  logic                         edge_r;

  logic [31:0]                      divisor_r;
  logic [15:0]                      quo_r;
  logic [15:0]                      rem_r;
  logic [ecg_hr_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic                         out_valid_r;
  logic [15:0]                  lead_two;
  logic [15:0]                  peak_new;
  logic [16:0]                  thr_sum;
  logic                         above_now;
  logic                         edge_now;
  logic [31:0]                  period;
  logic [16:0]                  trial;
  logic [16:0]                  diff;
  logic                         ge;
  logic [15:0]                  rem_nxt;
  logic [15:0]                  quo_nxt;

  assign lead_two = {pkt_r[2], pkt_r[3]};

  // framer
  assign eff_phase = in_rx_byte[7] ? phase_r : ecg_hr_pkg::PH_WAIT;

  always_comb begin
    phase_nxt = eff_phase;
    head_nxt  = head_r;
    count_nxt = count_r;
    case (eff_phase)
      ecg_hr_pkg::PH_WAIT: begin
        if (in_rx_byte == ecg_hr_pkg::ID_BYTE) begin
          phase_nxt = ecg_hr_pkg::PH_HEAD;
          count_nxt = 3'd0;
        end
      end
      ecg_hr_pkg::PH_HEAD: begin
        head_nxt  = in_rx_byte;
        phase_nxt = ecg_hr_pkg::PH_DATA;
      end
      ecg_hr_pkg::PH_DATA: begin
        count_nxt = count_r + 3'd1;
        if (count_r == ecg_hr_pkg::LAST_DATA_IDX) begin
          phase_nxt = ecg_hr_pkg::PH_LAST;
        end
      end
      ecg_hr_pkg::PH_LAST: begin
        phase_nxt = ecg_hr_pkg::PH_DONE;
      end
      default: begin
        phase_nxt = eff_phase;
      end
    endcase
  end

  assign stat.last_byte = (eff_phase == ecg_hr_pkg::PH_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= '0;
      phase_r    <= ecg_hr_pkg::PH_WAIT;
      head_r     <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        baseline_r <= cfg_wr_data;
      end
      if (cmd.byte_take) begin
        phase_r <= phase_nxt;
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_take && eff_phase == ecg_hr_pkg::PH_DATA) begin
      for (int i = 0; i < ecg_hr_pkg::NUM_LEAD_BYTES; i++) begin
        if (count_r == 3'(i)) begin
          pkt_r[i] <= {head_r[count_r], in_rx_byte[6:0]};
        end
      end
    end
    if (cmd.byte_take) begin
      time_r <= in_time_ms;
    end
  end

  // window peak and threshold
  assign peak_new = (fill_r == '0 || lead_two > peak_r) ? lead_two : peak_r;
  assign thr_sum  = {1'b0, baseline_r} + {1'b0, peak_new};

  // crossing detect
  assign above_now     = lead_two > thr_r;
  assign edge_now      = !above_r && above_now;
  assign period        = time_r - last_time_r;
  assign stat.need_div = edge_now && (period != '0);

  // restoring divider, one quotient bit per cycle
  assign trial   = {rem_r, quo_r[15]};
  assign ge      = {15'd0, trial} >= divisor_r;
  assign diff    = trial - divisor_r[16:0];
  assign rem_nxt = ge ? diff[15:0] : trial[15:0];
  assign quo_nxt = {quo_r[14:0], ge};
  assign stat.div_last = (div_cnt_r == ecg_hr_pkg::DIV_CNT_W'(ecg_hr_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      fill_r      <= '0;
      thr_r       <= '0;
      above_r     <= 1'b0;
      last_time_r <= '0;
      rate_r      <= ecg_hr_pkg::RATE_RESET;
      div_cnt_r   <= '0;
    end else begin
      if (cmd.peak_upd) begin
        peak_r <= peak_new;
        if (fill_r == ecg_hr_pkg::WIN_W'(ecg_hr_pkg::WINDOW_LEN - 1)) begin
          fill_r <= '0;
          thr_r  <= thr_sum[16:1];
        end else begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.edge_upd) begin
        above_r   <= above_now;
        div_cnt_r <= '0;
        if (edge_now) begin
          last_time_r <= time_r;
        end
      end
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (stat.div_last) begin
          rate_r <= quo_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_upd) begin
      edge_r    <= edge_now;
      divisor_r <= period;
      quo_r     <= ecg_hr_pkg::RATE_NUM;
      rem_r     <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // output register
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lead_one   <= {pkt_r[0], pkt_r[1]};
      out_lead_two   <= lead_two;
      out_lead_three <= {pkt_r[4], pkt_r[5]};
      out_heart_rate <= rate_r;
      out_beat_edge  <= edge_r;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPLY(a_div_nonzero, clk, rst_n, cmd.div_step, divisor_r != '0)
  `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall)
  `ASSERT_NEXT(a_done_after_last, clk, rst_n, cmd.byte_take && stat.last_byte,
    phase_r == ecg_hr_pkg::PH_DONE)

endmodule

// ===== hdl/ecg_hr_ctrl.sv =====
// Controller: sequences byte intake, heart-rate update, divider and result load
module ecg_hr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ecg_hr_pkg::dp_stat_t stat,
  output ecg_hr_pkg::dp_cmd_t  cmd
);

  ecg_hr_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecg_hr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecg_hr_pkg::ST_IDLE: begin
        if (in_valid && stat.last_byte) begin
          state_nxt = ecg_hr_pkg::ST_PEAK;
        end
      end
      ecg_hr_pkg::ST_PEAK: begin
        state_nxt = ecg_hr_pkg::ST_EDGE;
      end
      ecg_hr_pkg::ST_EDGE: begin
        state_nxt = stat.need_div ? ecg_hr_pkg::ST_DIV : ecg_hr_pkg::ST_OUT;
      end
      ecg_hr_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ecg_hr_pkg::ST_OUT;
        end
      end
      ecg_hr_pkg::ST_OUT: begin
        if (stat.out_free) begin
          state_nxt = ecg_hr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ecg_hr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ecg_hr_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.byte_take = in_valid;
      end
      ecg_hr_pkg::ST_PEAK: begin
        cmd.peak_upd = 1'b1;
      end
      ecg_hr_pkg::ST_EDGE: begin
        cmd.edge_upd = 1'b1;
      end
      ecg_hr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ecg_hr_pkg::ST_OUT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/ecg_packet_parser_heart_rate_unit.sv =====
// Top level: ECG packet parser with threshold heart-rate detector
// Non-final bytes are taken without stalling the input; the next byte may follow at once.
// A packet-ending byte holds the input through the peak, edge and output states, also through
// the bit-serial divider when a new rate is divided out, plus any wait for the output register.
// Its result beat is registered from the output state; loading the output register frees the input.
// Synchronous active-low reset: framer unsynchronised, rate 75, threshold and baseline 0.
module ecg_packet_parser_heart_rate_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_lead_one,
  output logic [15:0] out_lead_two,
  output logic [15:0] out_lead_three,
  output logic [15:0] out_heart_rate,
  output logic        out_beat_edge
);

  ecg_hr_pkg::dp_cmd_t  cmd;
  ecg_hr_pkg::dp_stat_t stat;

  ecg_hr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ecg_hr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_rx_byte     (in_rx_byte),
    .in_time_ms     (in_time_ms),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_lead_one   (out_lead_one),
    .out_lead_two   (out_lead_two),
    .out_lead_three (out_lead_three),
    .out_heart_rate (out_heart_rate),
    .out_beat_edge  (out_beat_edge),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== tb/testbench.sv =====
// Testbench for the ECG packet parser and heart-rate unit: framed byte stimulus, scoreboard
module testbench;

  localparam int FRAME_BYTES = 7;
  localparam int ITEM_TARGET = 1150;
  localparam int TAIL_RESERVE = 170;
  localparam int TAIL_UNITS = 10;
  localparam int UNITS_PER_PHASE = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [15:0] lead1;
    logic [15:0] lead2;
    logic [15:0] lead3;
    logic [15:0] rate;
    logic        beat_flag;
  } beat_rec_t;

  class ecg_frame_scoreboard;
    ecg_hr_pkg::parse_phase_t phase;
    logic [7:0]   msb_bits;
    logic [2:0]   data_idx;
    logic [7:0]   frame [FRAME_BYTES];
    logic [15:0]  baseline;
    logic [15:0]  peak;
    logic [15:0]  threshold;
    logic [15:0]  rate;
    int unsigned  fill;
    bit           above_prev;
    logic [31:0]  last_beat_ms;
    beat_rec_t    expected_beats[$];
    int           errors;
    int           checked;
    int           crossings;

    function new();
      phase = ecg_hr_pkg::PH_WAIT;
      msb_bits = '0;
      data_idx = '0;
      foreach (frame[i]) frame[i] = '0;
      baseline = '0;
      peak = '0;
      threshold = '0;
      rate = 16'd75;
      fill = 0;
      above_prev = 1'b0;
      last_beat_ms = '0;
      errors = 0;
      checked = 0;
      crossings = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // window peak, threshold and rising-crossing rate update for one lead-two sample
    function bit rate_update(logic [15:0] s, logic [31:0] now);
      bit          hit;
      bit          above;
      logic [31:0] period;
      logic [31:0] quot;
      logic [16:0] mid;
      hit = 1'b0;
      if (fill == 0 || s > peak) peak = s;
      fill++;
      if (fill >= ecg_hr_pkg::WINDOW_LEN) begin
        fill = 0;
        mid = {1'b0, baseline} + {1'b0, peak};
        threshold = mid[16:1];
      end
      above = (s > threshold);
      if (!above_prev && above) begin
        period = now - last_beat_ms;
        last_beat_ms = now;
        if (period != 0) begin
          quot = 32'd60000 / period;
          rate = quot[15:0];
        end
        hit = 1'b1;
      end
      above_prev = above;
      return hit;
    endfunction

    function void note_input(logic [7:0] b, logic [31:0] now);
      beat_rec_t r;
      int k;
      if (!b[7]) phase = ecg_hr_pkg::PH_WAIT;
      case (phase)
        ecg_hr_pkg::PH_WAIT: begin
          if (b == ecg_hr_pkg::ID_BYTE) begin
            phase = ecg_hr_pkg::PH_HEAD;
            data_idx = '0;
          end
        end
        ecg_hr_pkg::PH_HEAD: begin
          msb_bits = b;
          phase = ecg_hr_pkg::PH_DATA;
        end
        ecg_hr_pkg::PH_DATA: begin
          k = data_idx;
          if (k < FRAME_BYTES) frame[k] = {msb_bits[k], b[6:0]};
          data_idx = data_idx + 3'd1;
          if (data_idx >= FRAME_BYTES) phase = ecg_hr_pkg::PH_LAST;
        end
        ecg_hr_pkg::PH_LAST: begin
          phase = ecg_hr_pkg::PH_DONE;
          r.lead1 = {frame[0], frame[1]};
          r.lead2 = {frame[2], frame[3]};
          r.lead3 = {frame[4], frame[5]};
          r.beat_flag = rate_update(r.lead2, now);
          r.rate = rate;
          if (r.beat_flag) crossings++;
          expected_beats.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(beat_rec_t got);
      beat_rec_t want;
      checked++;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result beat with nothing expected: l1=%h l2=%h l3=%h hr=%0d e=%0b",
                   got.lead1, got.lead2, got.lead3, got.rate, got.beat_flag);
        return;
      end
      want = expected_beats.pop_front();
      if (got.lead1 !== want.lead1 || got.lead2 !== want.lead2 || got.lead3 !== want.lead3 ||
          got.rate !== want.rate || got.beat_flag !== want.beat_flag) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: beat %0d expected l1=%h l2=%h l3=%h hr=%0d e=%0b", checked,
                   want.lead1, want.lead2, want.lead3, want.rate, want.beat_flag);
          $display("       got      l1=%h l2=%h l3=%h hr=%0d e=%0b",
                   got.lead1, got.lead2, got.lead3, got.rate, got.beat_flag);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic [31:0] in_time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_lead_one;
  logic [15:0] out_lead_two;
  logic [15:0] out_lead_three;
  logic [15:0] out_heart_rate;
  logic        out_beat_edge;

  ecg_frame_scoreboard sb = new();
  beat_rec_t   seen_beat;
  int          bytes_in = 0;
  int          settings = 0;
  logic [31:0] cur_ms = '0;
  bit          freeze_ms = 1'b0;
  bit          calm = 1'b0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  bit          hold_req = 1'b0;

  ecg_packet_parser_heart_rate_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_time_ms     (in_time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lead_one   (out_lead_one),
    .out_lead_two   (out_lead_two),
    .out_lead_three (out_lead_three),
    .out_heart_rate (out_heart_rate),
    .out_beat_edge  (out_beat_edge)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_beat = '{out_lead_one, out_lead_two, out_lead_three, out_heart_rate, out_beat_edge};
        sb.check_result(seen_beat);
      end
      if (in_valid && !in_stall) begin
        sb.note_input(in_rx_byte, in_time_ms);
        bytes_in++;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && recv_gaps && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void advance_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) cur_ms = $urandom;
    else if (r < 6) cur_ms = cur_ms + $urandom_range(1000, 70000);
    else cur_ms = cur_ms + $urandom_range(0, 3);
  endfunction

  function automatic logic [15:0] pick_lead();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!calm && send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    if (!freeze_ms) advance_ms();
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_time_ms <= cur_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // ID, head carrying bit 7 of each data byte, seven data bytes, closing byte
  task automatic send_packet(input logic [15:0] l1, input logic [15:0] l2,
                             input logic [15:0] l3, input logic [7:0] b6);
    logic [7:0] d [FRAME_BYTES];
    logic [7:0] hd;
    d[0] = l1[15:8]; d[1] = l1[7:0];
    d[2] = l2[15:8]; d[3] = l2[7:0];
    d[4] = l3[15:8]; d[5] = l3[7:0];
    d[6] = b6;
    hd = 8'h80;
    for (int k = 0; k < FRAME_BYTES; k++) hd[k] = d[k][7];
    send_byte(ecg_hr_pkg::ID_BYTE);
    send_byte(hd);
    for (int k = 0; k < FRAME_BYTES; k++) send_byte({1'b1, d[k][6:0]});
    send_byte({1'b1, 7'($urandom_range(0, 127))});
  endtask

  task automatic random_unit();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      send_packet(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      repeat ($urandom_range(0, 2)) send_byte({1'b1, 7'($urandom_range(0, 127))});
    end else if (r < 75) begin
      send_packet(pick_lead(), pick_lead(), pick_lead(), 8'($urandom));
    end else if (r < 87) begin
      // framing cut short by a byte with bit 7 clear
      n = $urandom_range(0, 8);
      send_byte(ecg_hr_pkg::ID_BYTE);
      if (n > 0) send_byte({1'b1, 7'($urandom_range(0, 127))});
      for (int i = 1; i < n; i++) send_byte({1'b1, 7'($urandom_range(0, 127))});
      if ($urandom_range(0, 2) == 0) send_byte(ecg_hr_pkg::ID_BYTE);
      else send_byte({1'b0, 7'($urandom_range(0, 127))});
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_baseline(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.baseline = v;
    settings++;
  endtask

  initial begin
    int          phase_no;
    logic [15:0] v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wrong ID, done-phase byte, restart mid-packet, first crossing, zero period
    freeze_ms = 1'b1;
    cur_ms = 32'hFFFF_FFF0;
    send_byte(8'h05);
    send_byte(8'h88);
    send_packet(16'hFFFF, 16'hFFFF, 16'h0000, 8'h00);
    send_byte(8'hC3);
    send_byte(ecg_hr_pkg::ID_BYTE);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_packet(16'h0000, 16'h0000, 16'hFFFF, 8'hFF);
    send_packet(16'h8001, 16'h0001, 16'h7FFE, 8'h80);
    freeze_ms = 1'b0;
    drain();

    phase_no = 0;
    while (bytes_in < ITEM_TARGET - TAIL_RESERVE) begin
      send_gaps = (phase_no % 3) != 2;
      recv_gaps = (phase_no % 4) != 3;
      case (phase_no)
        0: v = 16'hFFFF;
        1: v = 16'h0000;
        default: begin
          case ($urandom_range(0, 3))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            default: v = 16'($urandom);
          endcase
        end
      endcase
      write_baseline(v);
      if (phase_no == 1) begin
        hold_req = 1'b1;
        send_gaps = 1'b0;
        repeat (5) send_packet(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        send_gaps = 1'b1;
      end
      repeat (UNITS_PER_PHASE) random_unit();
      drain();
      phase_no++;
    end

    calm = 1'b1;
    write_baseline(16'($urandom));
    repeat (TAIL_UNITS) random_unit();
    drain();

    $display("Run covered %0d input bytes, %0d packets, %0d threshold crossings, %0d baselines",
             bytes_in, sb.checked, sb.crossings, settings);
    $display("Included a %0d-cycle receiver hold-off with window length %0d",
             HOLD_CYCLES, ecg_hr_pkg::WINDOW_LEN);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
